@@ sv/gfa_pkg.sv @@
// shared types, constants and sigmoid table builders for the gated activation
package gfa_pkg;

	localparam int APPROX_TABLE_ENTRIES_DEF = 256;

	// register indexes
	localparam logic [1:0] REG_ACT_MODE = 2'd0;
	localparam logic [1:0] REG_GATE_EN  = 2'd1;

	// activation modes, every other code selects silu
	localparam logic [1:0] MODE_SILU  = 2'd0;
	localparam logic [1:0] MODE_RELU2 = 2'd1;
	localparam logic [1:0] MODE_GELU  = 2'd2;

	// fixed point constants
	localparam logic signed [15:0] GELU_C1 = 16'sd26145;
	localparam logic signed [15:0] GELU_C3 = 16'sd1169;
	localparam longint unsigned LOG2E_Q30 = 64'd1549082005;
	localparam longint unsigned LN2_Q30   = 64'd744261118;
	localparam longint Q30_ONE = 64'sd1073741824;
	localparam logic signed [12:0] SIG_ARG_MAX = 13'sd2048;
	localparam logic signed [12:0] SIG_ARG_MIN = -13'sd2048;

	// sideband that travels with each sample down the pipeline
	typedef struct packed {
		logic               valid;
		logic signed [15:0] x;
		logic signed [15:0] g;
		logic               last;
		logic [1:0]         mode;
		logic               gate_en;
	} side_t;

	// unsigned shift and subtract quotient, used only while the table is built
	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q;
		logic [64:0] rem;
		q = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-a) for a in q30, 0 <= a <= 8.0, result in q30
	function automatic longint exp_neg_q30(input longint unsigned a);
		logic [127:0] p;
		longint unsigned t;
		longint unsigned f;
		longint unsigned n;
		longint y;
		longint term;
		longint sum;
		p = {64'd0, a} * {64'd0, LOG2E_Q30};
		t = p[93:30];
		n = t >> 30;
		f = t & 64'h3fff_ffff;
		y = longint'((f * LN2_Q30) >> 30);
		term = Q30_ONE;
		sum = Q30_ONE;
		// series terms stay non-negative
		for (int i = 1; i <= 12; i++) begin
			term = signed'(udiv64(unsigned'((term * y) >>> 30), 64'(i)));
			sum = (i % 2 == 1) ? sum - term : sum + term;
		end
		if (n > 62)
			return 64'sd0;
		return sum >>> n;
	endfunction

	// one table entry, q0.16 sigmoid at -8 + 16k/n
	function automatic logic [16:0] sig_entry(input int n, input int k);
		longint num;
		longint unsigned mag;
		longint unsigned a;
		longint unsigned d;
		longint unsigned s;
		num = 64'sd16 * longint'(k) - 64'sd8 * longint'(n);
		mag = longint'(num < 0 ? -num : num);
		a = udiv64(mag << 30, 64'(n));
		d = longint'(Q30_ONE) + exp_neg_q30(a);
		s = udiv64((64'd1 << 46) + (d >> 1), d);
		return (num < 0) ? 17'(64'd65536 - s) : 17'(s);
	endfunction

endpackage

@@ sv/gated_ffn_activation.sv @@
// top level: config registers and the nine-stage activation pipeline
// a sample accepted on start passes the argument, sigmoid and output stages in order, then appears on done
// throughput: one sample per cycle, busy stays low, a new sample every cycle
// rate is set by the pipelined multipliers and the registered sigmoid table read
// reset clears the valid bits and sets act_mode to silu and gating off
// results are shown for one cycle on done; the receiver cannot stall
module gated_ffn_activation #(
	parameter int APPROX_TABLE_ENTRIES = gfa_pkg::APPROX_TABLE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] x_value,
	input  logic signed [15:0] gate_value,
	input  logic               last_in,
	output logic               done,
	output logic signed [15:0] y_value,
	output logic               last_out,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);
	import gfa_pkg::*;

	logic [1:0] act_mode_q;
	logic gate_enable_q;
	side_t side_in, side_s4, side_s7;
	logic signed [12:0] zc_s4;
	logic [16:0] sig_s7;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_mode_q <= MODE_SILU;
			gate_enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_ACT_MODE)
				act_mode_q <= cfg_data[1:0];
			else if (cfg_index == REG_GATE_EN)
				gate_enable_q <= cfg_data[0];
		end
	end

	// input transaction
	always_comb begin
		side_in.valid = start && !busy;
		side_in.x = x_value;
		side_in.g = gate_value;
		side_in.last = last_in;
		side_in.mode = act_mode_q;
		side_in.gate_en = gate_enable_q;
	end

	gfa_arg u_arg (
		.clk(clk), .arst_n(arst_n), .side_in(side_in),
		.side_s4(side_s4), .zc_s4(zc_s4)
	);

	gfa_sigmoid #(.APPROX_TABLE_ENTRIES(APPROX_TABLE_ENTRIES)) u_sig (
		.clk(clk), .arst_n(arst_n), .side_in(side_s4), .zc(zc_s4),
		.side_s7(side_s7), .sig_s7(sig_s7)
	);

	gfa_out u_out (
		.clk(clk), .arst_n(arst_n), .side_in(side_s7), .sig(sig_s7),
		.valid_s9(done), .y_s9(y_value), .last_s9(last_out)
	);

	// a result always traces back to a sample accepted at the pipeline input
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 9))
		else $error("result without matching transaction");

	// the last flag arrives with its own sample
	a_last_align: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> last_out == $past(last_in, 9))
		else $error("last flag misaligned");

	// mode write lands in the register
	a_mode_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == REG_ACT_MODE)
		|=> act_mode_q == $past(cfg_data[1:0]))
		else $error("act_mode write lost");

endmodule

@@ sv/gfa_arg.sv @@
// sigmoid argument stages: gelu cubic polynomial or plain x, clamped to +-8
module gfa_arg (
	input  logic               clk,
	input  logic               arst_n,
	input  gfa_pkg::side_t     side_in,
	output gfa_pkg::side_t     side_s4,
	output logic signed [12:0] zc_s4
);
	import gfa_pkg::*;

	side_t side_s1, side_s2, side_s3;
	logic signed [31:0] xx_s1, c1x_s1, c1x_s2, c1x_s3;
	logic signed [47:0] cube_s2;
	logic signed [58:0] c3c_s3;
	logic signed [63:0] acc;
	logic signed [63:0] z_full;
	logic signed [12:0] zc;

	// valid bits and payload: square, cube, scaled cube
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1.valid <= 1'b0;
			side_s2.valid <= 1'b0;
			side_s3.valid <= 1'b0;
			side_s4.valid <= 1'b0;
		end else begin
			side_s1.valid <= side_in.valid;
			side_s2.valid <= side_s1.valid;
			side_s3.valid <= side_s2.valid;
			side_s4.valid <= side_s3.valid;
			side_s1[$bits(side_t)-2:0] <= side_in[$bits(side_t)-2:0];
			xx_s1 <= side_in.x * side_in.x;
			c1x_s1 <= 32'(side_in.x) * 32'(GELU_C1);
			side_s2[$bits(side_t)-2:0] <= side_s1[$bits(side_t)-2:0];
			cube_s2 <= 48'(xx_s1) * 48'(side_s1.x);
			c1x_s2 <= c1x_s1;
			side_s3[$bits(side_t)-2:0] <= side_s2[$bits(side_t)-2:0];
			c3c_s3 <= 59'(cube_s2) * 59'(GELU_C3);
			c1x_s3 <= c1x_s2;
			side_s4[$bits(side_t)-2:0] <= side_s3[$bits(side_t)-2:0];
			zc_s4 <= zc;
		end
	end

	// sum, round by 2^30, clamp; every mode but gelu uses x directly
	always_comb begin
		acc = (64'(c1x_s3) <<< 16) + 64'(c3c_s3);
		z_full = (acc + 64'sd536870912) >>> 30;
		if (side_s3.mode != MODE_GELU)
			z_full = 64'(side_s3.x);
		if (z_full > 64'(SIG_ARG_MAX))
			zc = SIG_ARG_MAX;
		else if (z_full < 64'(SIG_ARG_MIN))
			zc = SIG_ARG_MIN;
		else
			zc = z_full[12:0];
	end

endmodule

@@ sv/gfa_sigmoid.sv @@
// sigmoid table lookup with linear interpolation, three stages
module gfa_sigmoid #(
	parameter int APPROX_TABLE_ENTRIES = gfa_pkg::APPROX_TABLE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gfa_pkg::side_t     side_in,
	input  logic signed [12:0] zc,
	output gfa_pkg::side_t     side_s7,
	output logic [16:0]        sig_s7
);
	import gfa_pkg::*;

	localparam int N = APPROX_TABLE_ENTRIES;
	localparam int IDX_W = $clog2(N + 1);
	localparam int POS_W = 12 + IDX_W;

	typedef logic [16:0] rom_t [0:N];

	function automatic rom_t build_rom();
		rom_t r;
		for (int k = 0; k <= N; k++)
			r[k] = sig_entry(N, k);
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	side_t side_s5, side_s6;
	logic [POS_W-1:0] pos_s5;
	logic [12:0] u;
	logic [IDX_W-1:0] k, k_next;
	logic [16:0] t0_s6, t1_s6;
	logic [11:0] f_s6;
	logic [30:0] interp;

	assign u = 13'(zc + 13'sd2048);
	assign k = pos_s5[POS_W-1:12];
	assign k_next = (k == IDX_W'(N)) ? k : k + 1'b1;

	// valid bits, table position, registered table read, interpolation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s5.valid <= 1'b0;
			side_s6.valid <= 1'b0;
			side_s7.valid <= 1'b0;
		end else begin
			side_s5.valid <= side_in.valid;
			side_s6.valid <= side_s5.valid;
			side_s7.valid <= side_s6.valid;
			side_s5[$bits(side_t)-2:0] <= side_in[$bits(side_t)-2:0];
			pos_s5 <= POS_W'(32'(u) * 32'(N));
			side_s6[$bits(side_t)-2:0] <= side_s5[$bits(side_t)-2:0];
			t0_s6 <= ROM[k];
			t1_s6 <= ROM[k_next];
			f_s6 <= pos_s5[11:0];
			side_s7[$bits(side_t)-2:0] <= side_s6[$bits(side_t)-2:0];
			sig_s7 <= interp[28:12];
		end
	end

	// weighted sum of neighboring entries
	assign interp = 31'(t0_s6) * 31'(13'd4096 - 13'(f_s6)) + 31'(t1_s6) * 31'(f_s6);

endmodule

@@ sv/gfa_out.sv @@
// activation product, optional gate product and saturation, two stages
module gfa_out (
	input  logic               clk,
	input  logic               arst_n,
	input  gfa_pkg::side_t     side_in,
	input  logic [16:0]        sig,
	output logic               valid_s9,
	output logic signed [15:0] y_s9,
	output logic               last_s9
);
	import gfa_pkg::*;

	logic signed [33:0] xs;
	logic signed [15:0] r;
	logic [29:0] rr;
	logic signed [23:0] v, v_s8;
	logic signed [15:0] g_s8;
	logic gate_s8, last_s8, valid_s8;
	logic signed [39:0] vg;
	logic signed [39:0] y_full;

	assign xs = 34'(side_in.x) * 34'($signed({1'b0, sig}));
	assign r = (side_in.x > 16'sd0) ? side_in.x : 16'sd0;
	assign rr = 30'(r) * 30'(r);

	// mode select and rounding of the activation
	always_comb begin
		if (side_in.mode == MODE_RELU2)
			v = 24'((rr + 30'd128) >> 8);
		else
			v = 24'((xs + 34'sd32768) >>> 16);
	end

	// gate product and saturation
	always_comb begin
		vg = 40'(v_s8) * 40'(g_s8);
		y_full = gate_s8 ? ((vg + 40'sd128) >>> 8) : 40'(v_s8);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			valid_s8 <= side_in.valid;
			valid_s9 <= valid_s8;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		v_s8 <= v;
		g_s8 <= side_in.g;
		gate_s8 <= side_in.gate_en;
		last_s8 <= side_in.last;
		last_s9 <= last_s8;
		if (y_full > 40'sd32767)
			y_s9 <= 16'sh7fff;
		else if (y_full < -40'sd32768)
			y_s9 <= 16'sh8000;
		else
			y_s9 <= y_full[15:0];
	end

endmodule
